### sv/hsf_pkg.sv
`default_nettype none
package hsf_pkg;

	// default coordinate format
	localparam int COORD_FRAC_BITS_DEF = 15;

	// internal working format
	localparam int WORK_FRAC = 24;
	localparam int MAG_W     = WORK_FRAC + 1;
	localparam int SQ_W      = 2 * MAG_W;
	localparam int RAD_W     = 58;
	localparam int ROOT_W    = RAD_W / 2;
	localparam int REM_W     = ROOT_W + 2;
	localparam int DEN_W     = ROOT_W + 1;
	localparam int Q_W       = 17;
	localparam int NUM_W     = DEN_W + Q_W;
	localparam int OUT_SHIFT = WORK_FRAC - 16;

	// dot shape codes
	localparam logic [1:0] SHAPE_ROUND   = 2'd0;
	localparam logic [1:0] SHAPE_ELLIPSE = 2'd1;
	localparam logic [1:0] SHAPE_SQUARE  = 2'd2;
	localparam logic [1:0] SHAPE_LINE    = 2'd3;

	// weights for squared distances, scaled by 100
	localparam logic [7:0] WEIGHT_UNIT    = 8'd100;
	localparam logic [7:0] WEIGHT_ELLIPSE = 8'd196;

	typedef struct packed {
		logic [RAD_W-1:0]  rad;
		logic [REM_W-1:0]  rem;
		logic [ROOT_W-1:0] root;
	} sqrt_lane_t;

	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [Q_W-1:0]   num;
		logic [Q_W-1:0]   quo;
	} div_lane_t;

endpackage
`default_nettype wire

### sv/hsf_sqrt_cell.sv
`default_nettype none
module hsf_sqrt_cell
	import hsf_pkg::*;
(
	input  wire logic       clk,
	input  wire sqrt_lane_t lane_in,
	output sqrt_lane_t      lane_s1
);

	logic [REM_W-1:0] cur;
	logic [REM_W-1:0] trial;

	// bring in two radicand bits and try the next root bit
	always_comb begin
		cur   = {lane_in.rem[REM_W-3:0], lane_in.rad[RAD_W-1 -: 2]};
		trial = {lane_in.root, 2'b01};
	end

	always_ff @(posedge clk) begin
		lane_s1.rad <= {lane_in.rad[RAD_W-3:0], 2'b00};
		if (cur >= trial) begin
			lane_s1.rem  <= cur - trial;
			lane_s1.root <= {lane_in.root[ROOT_W-2:0], 1'b1};
		end else begin
			lane_s1.rem  <= cur;
			lane_s1.root <= {lane_in.root[ROOT_W-2:0], 1'b0};
		end
	end

endmodule
`default_nettype wire

### sv/hsf_div_cell.sv
`default_nettype none
module hsf_div_cell
	import hsf_pkg::*;
(
	input  wire logic      clk,
	input  wire div_lane_t lane_in,
	output div_lane_t      lane_s1
);

	logic [DEN_W:0] cur;

	// shift in one dividend bit and try one quotient bit
	assign cur = {lane_in.rem, lane_in.num[Q_W-1]};

	always_ff @(posedge clk) begin
		lane_s1.den <= lane_in.den;
		lane_s1.num <= {lane_in.num[Q_W-2:0], 1'b0};
		if (cur >= {1'b0, lane_in.den}) begin
			lane_s1.rem <= DEN_W'(cur - {1'b0, lane_in.den});
			lane_s1.quo <= {lane_in.quo[Q_W-2:0], 1'b1};
		end else begin
			lane_s1.rem <= cur[DEN_W-1:0];
			lane_s1.quo <= {lane_in.quo[Q_W-2:0], 1'b0};
		end
	end

endmodule
`default_nettype wire

### sv/halftone_spot_function.sv
// a transaction accepted at one clock edge gives its done strobe after stages 1 to 3, the square-root cells,
// the denominator and dividend registers, the divider cells and the output register
// throughput: one transaction per cycle, busy is always low; the cell chains give one bit per cell
// the receiver cannot stall: each result is shown for exactly one cycle
// reset: asynchronous active-low arst_n clears dot_shape to round and all valid bits
`default_nettype none
module halftone_spot_function
	import hsf_pkg::*;
#(
	parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [1:0]                 cfg_wdata,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [COORD_FRAC_BITS:0]   x_coord,
	input  wire logic [COORD_FRAC_BITS:0]   y_coord,
	output logic                            done,
	output logic [Q_W-1:0]                  spot_value
);

	localparam int COORD_W = COORD_FRAC_BITS + 1;
	localparam int SIDE_N  = 3 + ROOT_W + 2 + Q_W;
	localparam int LAT     = SIDE_N + 1;

	logic [1:0] dot_shape_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_shape_q <= SHAPE_ROUND;
		end else if (cfg_we) begin
			dot_shape_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	logic               accept;
	logic [COORD_W-1:0] mag_x;
	logic [COORD_W-1:0] mag_y;
	logic [MAG_W-1:0]   ax;
	logic [MAG_W-1:0]   ay;
	logic [MAG_W-1:0]   amax;
	logic [MAG_W-1:0]   arnd;

	// magnitudes widened to the working format; -1 maps to exactly 1
	always_comb begin
		accept = start && !busy;
		mag_x  = x_coord[COORD_W-1] ? (~x_coord + 1'b1) : x_coord;
		mag_y  = y_coord[COORD_W-1] ? (~y_coord + 1'b1) : y_coord;
		ax     = MAG_W'(mag_x) << (WORK_FRAC - COORD_FRAC_BITS);
		ay     = MAG_W'(mag_y) << (WORK_FRAC - COORD_FRAC_BITS);
		amax   = (dot_shape_q == SHAPE_SQUARE && ax > ay) ? ax : ay;
		arnd   = amax + MAG_W'(1 << (OUT_SHIFT - 1));
	end

	logic [MAG_W-1:0] ax_s1, ay_s1, u_s1, v_s1;
	logic             ell_s1;

	// stage 1: magnitudes and corner distances
	always_ff @(posedge clk) begin
		ax_s1  <= ax;
		ay_s1  <= ay;
		u_s1   <= MAG_W'(1 << WORK_FRAC) - ax;
		v_s1   <= MAG_W'(1 << WORK_FRAC) - ay;
		ell_s1 <= (dot_shape_q == SHAPE_ELLIPSE);
	end

	logic [SQ_W-1:0] ax2_s2, ay2_s2, u2_s2, v2_s2;
	logic            ell_s2;

	// stage 2: squares
	always_ff @(posedge clk) begin
		ax2_s2 <= ax_s1 * ax_s1;
		ay2_s2 <= ay_s1 * ay_s1;
		u2_s2  <= u_s1 * u_s1;
		v2_s2  <= v_s1 * v_s1;
		ell_s2 <= ell_s1;
	end

	logic [7:0]       wgt;
	logic [RAD_W-1:0] sc_s3, sk_s3;

	// stage 3: weighted squared distances
	assign wgt = ell_s2 ? WEIGHT_ELLIPSE : WEIGHT_UNIT;

	always_ff @(posedge clk) begin
		sc_s3 <= RAD_W'(RAD_W'(ax2_s2) * WEIGHT_UNIT) + RAD_W'(RAD_W'(ay2_s2) * wgt);
		sk_s3 <= RAD_W'(RAD_W'(u2_s2) * WEIGHT_UNIT) + RAD_W'(RAD_W'(v2_s2) * wgt);
	end

	sqrt_lane_t lane_c [ROOT_W+1];
	sqrt_lane_t lane_k [ROOT_W+1];

	assign lane_c[0] = '{rad: sc_s3, rem: '0, root: '0};
	assign lane_k[0] = '{rad: sk_s3, rem: '0, root: '0};

	// square-root cell rows, one root bit per cell
	for (genvar i = 0; i < ROOT_W; i++) begin : g_sqrt
		hsf_sqrt_cell u_cell_c (.clk(clk), .lane_in(lane_c[i]), .lane_s1(lane_c[i+1]));
		hsf_sqrt_cell u_cell_k (.clk(clk), .lane_in(lane_k[i]), .lane_s1(lane_k[i+1]));
	end

	logic [DEN_W-1:0] sum;
	logic [DEN_W-1:0] den_s4;
	logic [ROOT_W-1:0] rc_s4;
	logic [NUM_W-1:0] num_s5;
	logic [DEN_W-1:0] den_s5;

	// denominator held at one lsb or more
	assign sum = DEN_W'(lane_c[ROOT_W].root) + DEN_W'(lane_k[ROOT_W].root);

	always_ff @(posedge clk) begin
		den_s4 <= (sum == '0) ? DEN_W'(1) : sum;
		rc_s4  <= lane_c[ROOT_W].root;
	end

	// rounded dividend
	always_ff @(posedge clk) begin
		num_s5 <= NUM_W'({rc_s4, 16'b0}) + NUM_W'(den_s4 >> 1);
		den_s5 <= den_s4;
	end

	div_lane_t lane_d [Q_W+1];

	assign lane_d[0] = '{rem: num_s5[NUM_W-1 -: DEN_W], den: den_s5,
		num: num_s5[Q_W-1:0], quo: '0};

	// divider cell row, one quotient bit per cell
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		hsf_div_cell u_cell_d (.clk(clk), .lane_in(lane_d[j]), .lane_s1(lane_d[j+1]));
	end

	logic             vld_s [SIDE_N];
	logic             alt_sel_s [SIDE_N];
	logic [Q_W-1:0]   alt_s [SIDE_N];

	// side line for valid, shape and the square or line result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SIDE_N; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= accept;
			for (int k = 1; k < SIDE_N; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		alt_sel_s[0] <= dot_shape_q[1];
		alt_s[0]     <= arnd[MAG_W-1:OUT_SHIFT];
		for (int k = 1; k < SIDE_N; k++) begin
			alt_sel_s[k] <= alt_sel_s[k-1];
			alt_s[k]     <= alt_s[k-1];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_s[SIDE_N-1];
		end
	end

	always_ff @(posedge clk) begin
		spot_value <= alt_sel_s[SIDE_N-1] ? alt_s[SIDE_N-1] : lane_d[Q_W].quo;
	end

	// a spot value never exceeds one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> spot_value <= Q_W'(1 << 16))
		else $error("spot value above one");

	// each accepted transaction gives its result after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LAT done)
		else $error("result strobe missing");

	// the divider remainder stays below the divisor
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[SIDE_N-1] && !alt_sel_s[SIDE_N-1] |-> lane_d[Q_W].rem < lane_d[Q_W].den)
		else $error("divider remainder out of range");

endmodule
`default_nettype wire

### tb/halftone_spot_function_test.sv
`default_nettype none
module halftone_spot_function_test;
	import hsf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = COORD_FRAC_BITS_DEF + 1;
	localparam int LATENCY = 52;

	// spot value predictor and store of pending spot values
	class spot_scoreboard;
		logic [1:0]     shape;
		logic [Q_W-1:0] spot_q[$];
		int             errors;
		int             checked;
		int             shape_items[4];

		function new();
			shape = SHAPE_ROUND;
			errors = 0;
			checked = 0;
			foreach (shape_items[i]) shape_items[i] = 0;
		endfunction

		// floor of a square root, one result bit per step
		function automatic longint unsigned int_sqrt(longint unsigned n);
			longint unsigned root;
			longint unsigned bitv;
			root = 0;
			bitv = 64'd1 << 62;
			while (bitv > n) bitv >>= 2;
			while (bitv != 0) begin
				if (n >= root + bitv) begin
					n -= root + bitv;
					root = (root >> 1) + bitv;
				end else begin
					root >>= 1;
				end
				bitv >>= 2;
			end
			return root;
		endfunction

		// magnitude in working format, -1.0 gives exactly 1.0
		function automatic longint unsigned magnitude(logic [CW-1:0] c);
			logic [CW:0] m;
			m = c[CW-1] ? ({1'b0, ~c} + 1'b1) : {1'b0, c};
			return longint'(m) << (WORK_FRAC - COORD_FRAC_BITS_DEF);
		endfunction

		// note an accepted transaction and predict its spot value
		function void note_coord(logic [CW-1:0] x, logic [CW-1:0] y);
			longint unsigned ax, ay, u, v, wgt, sc, sk, rc, rk, den, a, one;
			logic [Q_W-1:0] spot;
			ax = magnitude(x);
			ay = magnitude(y);
			one = 64'd1 << WORK_FRAC;
			shape_items[shape]++;
			case (shape)
				SHAPE_ROUND, SHAPE_ELLIPSE: begin
					wgt = (shape == SHAPE_ROUND) ? WEIGHT_UNIT : WEIGHT_ELLIPSE;
					u = one - ax;
					v = one - ay;
					sc = WEIGHT_UNIT * ax * ax + wgt * ay * ay;
					sk = WEIGHT_UNIT * u * u + wgt * v * v;
					rc = int_sqrt(sc);
					rk = int_sqrt(sk);
					den = rc + rk;
					if (den < 1) den = 1;
					spot = Q_W'((rc * 65536 + den / 2) / den);
				end
				SHAPE_SQUARE: begin
					a = (ax > ay) ? ax : ay;
					spot = Q_W'((a + 128) >> 8);
				end
				default: begin
					spot = Q_W'((ay + 128) >> 8);
				end
			endcase
			spot_q.insert(spot_q.size(), spot);
		endfunction

		// compare a result with the oldest pending spot value
		function void check_spot(logic [Q_W-1:0] actual);
			logic [Q_W-1:0] want;
			if (spot_q.size() == 0) begin
				$error("spot_value: unexpected result %0d", actual);
				errors++;
				return;
			end
			want = spot_q.pop_front();
			checked++;
			if (actual !== want) begin
				$error("spot_value: expected %0d actual %0d", want, actual);
				errors++;
			end
		endfunction
	endclass

	logic           clk;
	logic           arst_n;
	logic           cfg_we;
	logic [1:0]     cfg_wdata;
	logic           start;
	logic           busy;
	logic [CW-1:0]  x_coord;
	logic [CW-1:0]  y_coord;
	logic           done;
	logic [Q_W-1:0] spot_value;

	spot_scoreboard sb;

	halftone_spot_function dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.start(start),
		.busy(busy),
		.x_coord(x_coord),
		.y_coord(y_coord),
		.done(done),
		.spot_value(spot_value)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// monitor: register writes, accepted transactions, results
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) sb.shape = cfg_wdata;
			if (start && !busy) sb.note_coord(x_coord, y_coord);
			if (done) sb.check_spot(spot_value);
		end
	end

	// run limit
	initial begin
		#5ms;
		$display("halftone_spot_function_test: FAIL");
		$finish;
	end

	task automatic write_shape(logic [1:0] s);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = s;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one transaction, after a random idle gap
	task automatic send_coord(logic [CW-1:0] x, logic [CW-1:0] y, int idle_pct);
		while ($urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		x_coord = x;
		y_coord = y;
		do @(posedge clk); while (busy);
		@(negedge clk);
		start = 1'b0;
	endtask

	// wait for every pending result, then let the pipeline settle
	task automatic drain();
		while (sb.spot_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 8) @(negedge clk);
	endtask

	function automatic logic [CW-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(CW-1){1'b0}}};
			1: return {1'b0, {(CW-1){1'b1}}};
			2: return CW'($urandom_range(0, 3));
			3: return CW'(-$urandom_range(1, 4));
			default: return CW'($urandom_range(0, (1 << CW) - 1));
		endcase
	endfunction

	initial begin
		logic [CW-1:0] pts[6][2];
		int idle_pct[3];
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		start = 1'b0;
		x_coord = '0;
		y_coord = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed corner and centre points under every shape
		pts[0] = '{16'sh8000, 16'sh8000};
		pts[1] = '{16'sh7fff, 16'sh7fff};
		pts[2] = '{16'sh0000, 16'sh0000};
		pts[3] = '{16'sh8000, 16'sh0000};
		pts[4] = '{16'sh0000, 16'sh7fff};
		pts[5] = '{16'sh0001, 16'shffff};
		for (int s = 3; s >= 0; s--) begin
			write_shape(2'(s));
			foreach (pts[i]) send_coord(pts[i][0], pts[i][1], 0);
			drain();
		end

		// random phases: each shape under each idle pattern
		idle_pct = '{0, 67, 9};
		for (int ph = 0; ph < 12; ph++) begin
			write_shape(2'(ph % 4));
			for (int n = 0; n < 108; n++)
				send_coord(rand_coord(), rand_coord(), idle_pct[ph / 4]);
			drain();
		end

		$display("covered %0d results: round %0d, elliptical %0d, square %0d, line %0d",
			sb.checked, sb.shape_items[SHAPE_ROUND], sb.shape_items[SHAPE_ELLIPSE],
			sb.shape_items[SHAPE_SQUARE], sb.shape_items[SHAPE_LINE]);
		if (sb.spot_q.size() != 0) begin
			$error("spot_value: %0d results never arrived", sb.spot_q.size());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("halftone_spot_function_test: PASS");
		else
			$display("halftone_spot_function_test: FAIL");
		$finish;
	end
endmodule
`default_nettype wire
